### sv/esd_pkg.sv
package esd_pkg;

    // Character codes used by the decoder
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_TAB  = 8'h09;

    // Buffer size after reset
    localparam logic [15:0] BUF_SIZE_RESET = 16'd4096;

    // Queue between decoder front and buffer back end
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One result slot: a decoded byte or a format error
    typedef struct packed {
        logic       err;
        logic [7:0] data;
    } t_slot;

    // One decoded input character: one or two result slots
    typedef struct packed {
        logic  two;
        t_slot s0;
        t_slot s1;
    } t_rec;

    // Front to queue write side
    typedef struct packed {
        logic push;
        t_rec rec;
    } t_qpush;

endpackage

### sv/escape_sequence_decoder.sv
// Escape sequence decoder with write buffer fill accounting.
// Input channel: i_in_valid / o_in_stall carry one string character
// (i_char_in) and i_end_of_string on its final character; a transaction
// completes on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one result per
// transaction: decoded byte, its buffer index, flush request, status and
// o_last on the final result of an input character. A character gives zero,
// one or two results.
// Config channel: i_cfg_valid / o_cfg_ready write buffer_size; ready is high
// only while no result is queued or held.
// o_out_valid rises once the input transaction has passed the queue write
// and then the output register. Throughput: one character per cycle for
// one-result characters while not stalled; a two-result character (octal
// run ended by another character) holds the result port for both results,
// as the back end emits one result per cycle. A 4-entry queue absorbs bursts.
// Reset (synchronous, active low): decode mode normal, fill count 0,
// buffer_size 4096, queue empty.
// When the receiver stalls, the output register holds its result; the queue
// fills and o_in_stall rises once it is full.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_string,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_buffer_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [15:0] o_buffer_index,
    output logic        o_flush_request,
    output logic        o_status,
    output logic        o_last
);

    t_qpush qpush;
    logic   q_full;
    logic   q_valid;
    t_rec   q_rec;
    logic   q_pop;

    // Character classification
    esd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_qpush         (qpush)
    );

    // Decoupling queue
    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qpush (qpush),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (q_pop)
    );

    // Buffer accounting and result output
    esd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_rec         (q_rec),
        .o_q_pop         (q_pop),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_buffer_size   (i_buffer_size),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_buffer_index  (o_buffer_index),
        .o_flush_request (o_flush_request),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

### sv/esd_front.sv
module esd_front
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_string,
    input  logic       i_q_full,
    output t_qpush     o_qpush
);

    typedef enum logic [3:0] {
        M_NORMAL = 4'b0001,
        M_ESCAPE = 4'b0010,
        M_OCT1   = 4'b0100,
        M_OCT2   = 4'b1000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [5:0]  r_acc, n_acc;
    logic        r_disc, n_disc;

    logic        accept;
    logic        is_oct;
    logic [2:0]  digit;
    logic [8:0]  oct_val;
    logic        oct_emit;
    logic [7:0]  oct_byte;
    logic        dec_emit;
    t_slot       dec_slot;
    logic        do_dec;
    logic        dec_esc;
    logic        err;
    t_rec        rec;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign is_oct     = (i_char_in >= CH_ZERO) && (i_char_in <= CH_SEVEN);
    assign digit      = i_char_in[2:0];
    assign oct_val    = {r_acc, digit};

    // Classify one character against the current decode mode
    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_disc   = r_disc;
        oct_emit = 1'b0;
        oct_byte = {2'b00, r_acc};
        dec_emit = 1'b0;
        dec_slot = '{err: 1'b0, data: i_char_in};
        do_dec   = 1'b0;
        dec_esc  = 1'b0;
        err      = 1'b0;

        if (r_disc) begin
            if (i_end_of_string) begin
                n_disc = 1'b0;
                n_mode = M_NORMAL;
                n_acc  = '0;
            end
        end else begin
            unique case (r_mode)
                M_OCT1, M_OCT2: begin
                    if (is_oct) begin
                        if (r_mode == M_OCT2 || i_end_of_string) begin
                            oct_emit = 1'b1;
                            oct_byte = oct_val[7:0];
                            n_mode   = M_NORMAL;
                            n_acc    = '0;
                        end else begin
                            n_mode = M_OCT2;
                            n_acc  = oct_val[5:0];
                        end
                    end else begin
                        // run ended: flush it, then decode this char afresh
                        oct_emit = 1'b1;
                        n_mode   = M_NORMAL;
                        n_acc    = '0;
                        do_dec   = 1'b1;
                    end
                end
                M_ESCAPE: begin
                    do_dec  = 1'b1;
                    dec_esc = 1'b1;
                end
                default: begin
                    do_dec = 1'b1;
                end
            endcase

            if (do_dec) begin
                if (!dec_esc) begin
                    if (i_char_in == CH_BSLASH) begin
                        if (i_end_of_string) begin
                            err = 1'b1;
                        end else begin
                            n_mode = M_ESCAPE;
                        end
                    end else begin
                        dec_emit = 1'b1;
                    end
                end else begin
                    n_mode = M_NORMAL;
                    unique case (i_char_in)
                        CH_N: begin
                            dec_emit      = 1'b1;
                            dec_slot.data = BYTE_LF;
                        end
                        CH_R: begin
                            dec_emit      = 1'b1;
                            dec_slot.data = BYTE_CR;
                        end
                        CH_T: begin
                            dec_emit      = 1'b1;
                            dec_slot.data = BYTE_TAB;
                        end
                        CH_DQUOTE, CH_BSLASH: begin
                            dec_emit = 1'b1;
                        end
                        default: begin
                            if (is_oct) begin
                                if (i_end_of_string) begin
                                    dec_emit      = 1'b1;
                                    dec_slot.data = {5'b00000, digit};
                                    n_acc         = '0;
                                end else begin
                                    n_mode = M_OCT1;
                                    n_acc  = {3'b000, digit};
                                end
                            end else begin
                                err = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // bad escape: one error result, drop the rest of the string
            if (err) begin
                dec_emit = 1'b1;
                dec_slot = '{err: 1'b1, data: 8'h00};
                n_mode   = M_NORMAL;
                n_acc    = '0;
                if (!i_end_of_string) begin
                    n_disc = 1'b1;
                end
            end

            if (i_end_of_string) begin
                n_mode = M_NORMAL;
                n_acc  = '0;
            end
        end
    end

    // Pack results into one queue entry
    always_comb begin
        if (oct_emit) begin
            rec.two = dec_emit;
            rec.s0  = '{err: 1'b0, data: oct_byte};
            rec.s1  = dec_slot;
        end else begin
            rec.two = 1'b0;
            rec.s0  = dec_slot;
            rec.s1  = dec_slot;
        end
    end

    assign o_qpush.push = accept && (oct_emit || dec_emit);
    assign o_qpush.rec  = rec;

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_acc  <= '0;
            r_disc <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_disc <= n_disc;
        end
    end

endmodule

### sv/esd_queue.sv
module esd_queue
    import esd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qpush i_qpush,
    output logic   o_full,
    output logic   o_valid,
    output t_rec   o_rec,
    input  logic   i_pop
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_qpush.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_qpush.rec;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_qpush.push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

### sv/esd_back.sv
module esd_back
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_rec        i_q_rec,
    output logic        o_q_pop,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_buffer_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [15:0] o_buffer_index,
    output logic        o_flush_request,
    output logic        o_status,
    output logic        o_last
);

    logic [15:0] r_size;
    logic [15:0] r_fill;
    logic        r_slot;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_byte_valid;
    logic [15:0] r_buffer_index;
    logic        r_flush_request;
    logic        r_status;
    logic        r_last;

    logic        load;
    logic        pop;
    t_slot       cur;
    logic [16:0] next_cnt;
    logic        flush;

    // Pick the slot to emit and work out the fill advance
    assign load     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign cur      = r_slot ? i_q_rec.s1 : i_q_rec.s0;
    assign pop      = load && (!i_q_rec.two || r_slot);
    assign next_cnt = {1'b0, r_fill} + 17'd1;
    assign flush    = !cur.err && (next_cnt >= {1'b0, r_size});

    assign o_q_pop     = pop;
    assign o_cfg_ready = !i_q_valid && !r_out_valid;

    // Buffer size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= BUF_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size <= i_buffer_size;
        end
    end

    // Fill count and slot sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_slot      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_slot      <= !pop;
                r_out_valid <= 1'b1;
                if (!cur.err) begin
                    r_fill <= flush ? 16'd0 : next_cnt[15:0];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte      <= cur.data;
            r_byte_valid    <= !cur.err;
            r_buffer_index  <= r_fill;
            r_flush_request <= flush;
            r_status        <= cur.err;
            r_last          <= pop;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_byte_valid;
    assign o_buffer_index  = r_buffer_index;
    assign o_flush_request = r_flush_request;
    assign o_status        = r_status;
    assign o_last          = r_last;

    a_flush_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && flush) |=> (r_fill == 16'd0))
        else $error("fill count not restarted after flush");

    a_slot_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot |-> (i_q_valid && i_q_rec.two))
        else $error("second slot pending without a two-result entry");

    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> (!r_byte_valid && !r_flush_request))
        else $error("error result carries a byte");

endmodule
